// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the link keeping checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/lkdv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkdv_pkg
// Types, widths and helpers shared by the link keeping drive vector block.
// ----------------------------------------------------------------------------
package lkdv_pkg;

	localparam int unsigned LKDV_MAX_NEIGHBOURS = 8;
	localparam int unsigned CNT_W      = 4;
	localparam int unsigned COORD_W    = 16;
	localparam int unsigned SQ_W       = 32;
	localparam int unsigned ROOT_W     = 16;
	localparam int unsigned DRIVE_W    = 15;
	localparam int unsigned QUO_W      = 15;
	localparam int unsigned PROD_W     = DRIVE_W + COORD_W;
	localparam int unsigned SQRT_STEPS = 16;
	localparam int unsigned DIV_STEPS  = 15;

	// Register map, decoded on the word address bit
	typedef enum logic {
		REG_REACH = 1'b0,
		REG_DRIVE = 1'b1
	} reg_idx_t;

	// Frame summary handed from the qualifier to the scaler
	typedef struct packed {
		logic                       found;
		logic signed [COORD_W-1:0]  held_x;
		logic signed [COORD_W-1:0]  held_y;
		logic [CNT_W-1:0]           held_index;
		logic [SQ_W-1:0]            held_sq;
	} frame_t;

	// Magnitude of a signed coordinate; the most negative value maps to 2^15
	function automatic logic [COORD_W-1:0] mag16(input logic signed [COORD_W-1:0] v);
		logic [COORD_W-1:0] m;
		m = v[COORD_W-1] ? (~v + 1'b1) : v;
		return m;
	endfunction

endpackage

// ----- design/lkdv_arith.sv -----
// ----------------------------------------------------------------------------
// lkdv_arith
// Shared add, subtract and compare unit: diff = a - (b + c), ge = a >= b + c.
// ----------------------------------------------------------------------------
module lkdv_arith import lkdv_pkg::*; (
	input  logic [SQ_W-1:0] a,
	input  logic [SQ_W-1:0] b,
	input  logic [SQ_W-1:0] c,
	output logic            ge,
	output logic [SQ_W-1:0] diff
);

	logic [SQ_W-1:0] sum;
	logic [SQ_W:0]   delta;

	// Form the trial value, then subtract it with a borrow bit
	assign sum   = b + c;
	assign delta = {1'b0, a} - {1'b0, sum};
	assign ge    = ~delta[SQ_W];
	assign diff  = delta[SQ_W-1:0];

endmodule

// ----- design/lkdv_qualify.sv -----
// ----------------------------------------------------------------------------
// lkdv_qualify
// Takes neighbour beats, squares offsets on one shared multiplier and keeps
// the lowest-index neighbour beyond reach; hands the frame on at its end.
// ----------------------------------------------------------------------------
module lkdv_qualify import lkdv_pkg::*; #(
	parameter int unsigned MAX_NEIGHBOURS = LKDV_MAX_NEIGHBOURS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] offset_x,
	input  logic signed [COORD_W-1:0] offset_y,
	input  logic                      present,
	input  logic                      frame_end,
	input  logic [COORD_W-1:0]        reach_threshold,
	output frame_t                    frame,
	output logic                      frame_valid,
	input  logic                      frame_take
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic                      found_q;
	logic signed [COORD_W-1:0] hx_q;
	logic signed [COORD_W-1:0] hy_q;
	logic [CNT_W-1:0]          hidx_q;
	logic [SQ_W-1:0]           hsq_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic [CNT_W-1:0]          idx_q;
	logic [COORD_W-1:0]        th_q;
	logic                      last_q;
	logic [SQ_W-1:0]           acc_q;

	logic [COORD_W-1:0]        mul_op;
	logic [SQ_W-1:0]           prod;
	logic                      accept;
	logic                      scan;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && (state_q == ST_IDLE);
	assign scan        = (cnt_q < CNT_W'(MAX_NEIGHBOURS));
	assign frame_valid = (state_q == ST_DONE);
	assign frame       = '{found: found_q, held_x: hx_q, held_y: hy_q,
		held_index: hidx_q, held_sq: hsq_q};

	// Pick the squaring operand for the current step
	always_comb begin
		unique case (state_q)
			ST_SQX:  mul_op = mag16(x_q);
			ST_SQY:  mul_op = mag16(y_q);
			default: mul_op = th_q;
		endcase
	end

	assign prod = {{(SQ_W-COORD_W){1'b0}}, mul_op} * {{(SQ_W-COORD_W){1'b0}}, mul_op};

	// Sequence one beat: x squared, add y squared, compare with reach squared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			found_q <= 1'b0;
			hx_q    <= '0;
			hy_q    <= '0;
			hidx_q  <= '0;
			hsq_q   <= '0;
			cnt_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			idx_q   <= '0;
			th_q    <= '0;
			last_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q    <= offset_x;
						y_q    <= offset_y;
						idx_q  <= cnt_q;
						th_q   <= reach_threshold;
						last_q <= frame_end;
						if (scan) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (scan && present && !found_q) begin
							state_q <= ST_SQX;
						end else if (frame_end) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SQX: begin
					acc_q   <= prod;
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					acc_q   <= acc_q + prod;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// Strictly beyond reach captures this neighbour
					if (acc_q > prod) begin
						found_q <= 1'b1;
						hx_q    <= x_q;
						hy_q    <= y_q;
						hidx_q  <= idx_q;
						hsq_q   <= acc_q;
					end
					state_q <= last_q ? ST_DONE : ST_IDLE;
				end
				ST_DONE: begin
					// Drop the frame state once the scaler has it
					if (frame_take) begin
						found_q <= 1'b0;
						hx_q    <= '0;
						hy_q    <= '0;
						hidx_q  <= '0;
						hsq_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/lkdv_scale.sv -----
// ----------------------------------------------------------------------------
// lkdv_scale
// Square root of the held squared distance, then drive_gain * |d| / root for
// each axis, root and divides on one shared subtract unit; holds the result beat.
// ----------------------------------------------------------------------------
module lkdv_scale import lkdv_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  frame_t                    frame,
	input  logic                      frame_valid,
	output logic                      frame_take,
	input  logic [DRIVE_W-1:0]        drive_gain,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] drive_x,
	output logic signed [COORD_W-1:0] drive_y,
	output logic                      has_signal,
	output logic [CNT_W-1:0]          chosen_index
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQRT,
		S_MULX,
		S_DIVX,
		S_MULY,
		S_DIVY,
		S_OUT
	} state_t;

	state_t                    state_q;
	frame_t                    fr_q;
	logic [DRIVE_W-1:0]        md_q;
	logic [SQ_W-1:0]           rem_q;
	logic [SQ_W-1:0]           res_q;
	logic [SQ_W-1:0]           bit_q;
	logic [QUO_W-1:0]          dvd_q;
	logic [QUO_W-1:0]          quo_q;
	logic [CNT_W-1:0]          step_q;
	logic [COORD_W-1:0]        drvx_q;
	logic [COORD_W-1:0]        drvy_q;
	logic                      out_valid_q;
	logic signed [COORD_W-1:0] drive_x_q;
	logic signed [COORD_W-1:0] drive_y_q;
	logic                      has_signal_q;
	logic [CNT_W-1:0]          chosen_index_q;

	logic [SQ_W-1:0]           op_a;
	logic [SQ_W-1:0]           op_b;
	logic [SQ_W-1:0]           op_c;
	logic                      ge;
	logic [SQ_W-1:0]           diff;
	logic [COORD_W-1:0]        mag;
	logic [PROD_W-1:0]         prod;
	logic [QUO_W-1:0]          quo_next;
	logic [COORD_W-1:0]        quo_ext;
	logic                      neg;
	logic [COORD_W-1:0]        quo_signed;
	logic                      out_free;

	lkdv_arith u_arith (
		.a    (op_a),
		.b    (op_b),
		.c    (op_c),
		.ge   (ge),
		.diff (diff)
	);

	// Route the shared unit: root trial in square root, divisor compare in divide
	always_comb begin
		if (state_q == S_SQRT) begin
			op_a = rem_q;
			op_b = res_q;
			op_c = bit_q;
		end else begin
			op_a = {{(SQ_W-ROOT_W-1){1'b0}}, rem_q[ROOT_W-1:0], dvd_q[QUO_W-1]};
			op_b = {{(SQ_W-ROOT_W){1'b0}}, res_q[ROOT_W-1:0]};
			op_c = '0;
		end
	end

	assign mag  = (state_q == S_MULX) ? mag16(fr_q.held_x) : mag16(fr_q.held_y);
	assign prod = PROD_W'(md_q) * PROD_W'(mag);

	// Next quotient and its sign for the axis being divided
	assign quo_next   = {quo_q[QUO_W-2:0], ge};
	assign quo_ext    = {1'b0, quo_next};
	assign neg        = (state_q == S_DIVX) ? fr_q.held_x[COORD_W-1] : fr_q.held_y[COORD_W-1];
	assign quo_signed = neg ? (~quo_ext + 1'b1) : quo_ext;

	assign frame_take = (state_q == S_IDLE) && frame_valid;
	assign out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fr_q           <= '0;
			md_q           <= '0;
			rem_q          <= '0;
			res_q          <= '0;
			bit_q          <= '0;
			dvd_q          <= '0;
			quo_q          <= '0;
			step_q         <= '0;
			drvx_q         <= '0;
			drvy_q         <= '0;
			out_valid_q    <= 1'b0;
			drive_x_q      <= '0;
			drive_y_q      <= '0;
			has_signal_q   <= 1'b0;
			chosen_index_q <= '0;
		end else begin
			// Raise the result beat when loaded, drop it once taken
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (frame_valid) begin
						fr_q    <= frame;
						md_q    <= drive_gain;
						rem_q   <= frame.held_sq;
						res_q   <= '0;
						bit_q   <= {2'b01, {(SQ_W-2){1'b0}}};
						step_q  <= '0;
						state_q <= frame.found ? S_SQRT : S_OUT;
					end
				end
				S_SQRT: begin
					// One root bit per cycle
					if (ge) begin
						rem_q <= diff;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q  <= bit_q >> 2;
					step_q <= step_q + 1'b1;
					if (step_q == CNT_W'(SQRT_STEPS - 1)) begin
						state_q <= S_MULX;
					end
				end
				S_MULX, S_MULY: begin
					// Upper product bits start below the root, so fifteen steps suffice
					rem_q   <= {{(SQ_W-ROOT_W){1'b0}}, prod[PROD_W-1:QUO_W]};
					dvd_q   <= prod[QUO_W-1:0];
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= (state_q == S_MULX) ? S_DIVX : S_DIVY;
				end
				S_DIVX, S_DIVY: begin
					// Restoring divide, one quotient bit per cycle
					rem_q  <= ge ? diff : op_a;
					quo_q  <= quo_next;
					dvd_q  <= {dvd_q[QUO_W-2:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == CNT_W'(DIV_STEPS - 1)) begin
						if (state_q == S_DIVX) begin
							drvx_q  <= quo_signed;
							state_q <= S_MULY;
						end else begin
							drvy_q  <= quo_signed;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					// Load the result once the output register is free
					if (out_free) begin
						drive_x_q      <= fr_q.found ? drvx_q : '0;
						drive_y_q      <= fr_q.found ? drvy_q : '0;
						has_signal_q   <= fr_q.found;
						chosen_index_q <= fr_q.found ? fr_q.held_index : '0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_x      = drive_x_q;
	assign drive_y      = drive_y_q;
	assign has_signal   = has_signal_q;
	assign chosen_index = chosen_index_q;

endmodule

// ----- design/link_keeping_drive_vector.sv -----
// ----------------------------------------------------------------------------
// link_keeping_drive_vector
// Picks the first neighbour beyond reach in a frame and emits a drive vector
// of fixed magnitude toward it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat per neighbour in index order, taken when in_valid
//   is high and in_stall low. A beat that is squared and compared stalls the
//   input through the square x, square y and compare states; a last beat then
//   holds the input until the scaler takes the frame.
//   Output channel: one beat per frame. With a chosen neighbour, the scaler
//   runs 16 square root steps, then per axis one multiply and 15 divide steps,
//   the root and divide steps on one shared subtract and compare unit. With
//   none, the scaler goes straight to its output state.
//   The next frame's beats are taken while the result is computed.
//   A stalled result holds in the output register until taken.
//   Reset clears both registers, the frame state and any pending result.
//   Registers (APB): 0x0 reach_threshold, 0x4 drive gain.
// ----------------------------------------------------------------------------
module link_keeping_drive_vector import lkdv_pkg::*; #(
	parameter int unsigned MAX_NEIGHBOURS = LKDV_MAX_NEIGHBOURS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] offset_x,
	input  logic signed [COORD_W-1:0] offset_y,
	input  logic                      present,
	input  logic                      frame_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] drive_x,
	output logic signed [COORD_W-1:0] drive_y,
	output logic                      has_signal,
	output logic [CNT_W-1:0]          chosen_index
);

	logic [COORD_W-1:0] reach_q;
	logic [DRIVE_W-1:0] maxd_q;
	reg_idx_t           reg_sel;
	frame_t             frame;
	logic               frame_valid;
	logic               frame_take;

	assign reg_sel = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= '0;
			maxd_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_REACH: reach_q <= pwdata[COORD_W-1:0];
				REG_DRIVE: maxd_q  <= pwdata[DRIVE_W-1:0];
				default:   reach_q <= reach_q;
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		unique case (reg_sel)
			REG_REACH: prdata = {{(32-COORD_W){1'b0}}, reach_q};
			REG_DRIVE: prdata = {{(32-DRIVE_W){1'b0}}, maxd_q};
			default:   prdata = '0;
		endcase
	end

	lkdv_qualify #(
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS)
	) u_qualify (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.offset_x        (offset_x),
		.offset_y        (offset_y),
		.present         (present),
		.frame_end       (frame_end),
		.reach_threshold (reach_q),
		.frame           (frame),
		.frame_valid     (frame_valid),
		.frame_take      (frame_take)
	);

	lkdv_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.frame_valid  (frame_valid),
		.frame_take   (frame_take),
		.drive_gain   (maxd_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_x      (drive_x),
		.drive_y      (drive_y),
		.has_signal   (has_signal),
		.chosen_index (chosen_index)
	);

endmodule

// ----- design/lkdv_checker.sv -----
// ----------------------------------------------------------------------------
// lkdv_checker
// Port-level checks on the result channel of the link keeping block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lkdv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] drive_x,
	input logic [15:0] drive_y,
	input logic        has_signal,
	input logic [3:0]  chosen_index
);

	logic [36:0] out_payload;
	logic        no_drive;
	logic        in_range;

	assign out_payload = {drive_x, drive_y, has_signal, chosen_index};
	assign no_drive    = (drive_x == 16'd0) && (drive_y == 16'd0) && (chosen_index == 4'd0);
	assign in_range    = (drive_x != 16'h8000) && (drive_y != 16'h8000);

	// A stalled result beat stays offered
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped under stall")

	// A stalled result beat keeps its payload
	`CHK_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_payload), "result changed")

	// No neighbour found means an all-zero result
	`CHK_SAME(a_no_signal_zero, clk, arst_n, out_valid && !has_signal, no_drive, "nonzero result")

	// Scaled drive never reaches the most negative code
	`CHK_SAME(a_drive_range, clk, arst_n, out_valid, in_range, "drive out of range")

endmodule

bind link_keeping_drive_vector lkdv_checker u_lkdv_checker (.*);

// ----- dv/link_keeping_drive_vector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_keeping_drive_vector_tb
// Drives frames of neighbour offsets through the input channel and checks
// every drive beat against a cycle-free model of the weak-link choice and the
// square root and divide scaling. The registers are set over APB between
// frames. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module link_keeping_drive_vector_tb;
	import lkdv_pkg::*;

	localparam int SETTLE_CYCLES = 64;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      sig;
		logic [CNT_W-1:0]          idx;
	} drive_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [2:0]                paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [COORD_W-1:0] offset_x;
	logic signed [COORD_W-1:0] offset_y;
	logic                      present;
	logic                      frame_end;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [COORD_W-1:0] drive_x;
	logic signed [COORD_W-1:0] drive_y;
	logic                      has_signal;
	logic [CNT_W-1:0]          chosen_index;

	// Model state: register copies and the frame being gathered
	logic [15:0]               cfg_reach;
	logic [14:0]               cfg_drive;
	logic                      held_found;
	logic signed [COORD_W-1:0] held_x;
	logic signed [COORD_W-1:0] held_y;
	logic [CNT_W-1:0]          held_idx;
	int                        beat_count;
	drive_result_t             expected_drives[$];

	int error_count;
	int gap_pct;
	int stall_pct;

	link_keeping_drive_vector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.offset_x     (offset_x),
		.offset_y     (offset_y),
		.present      (present),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_x      (drive_x),
		.drive_y      (drive_y),
		.has_signal   (has_signal),
		.chosen_index (chosen_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("link_keeping_drive_vector verification failed");
		$finish;
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Integer square root, rounded down
	function automatic longint floor_sqrt(input longint v);
		longint root;
		longint cand;
		root = 0;
		for (int b = 16; b >= 0; b--) begin
			cand = root | (longint'(1) << b);
			if (cand * cand <= v)
				root = cand;
		end
		return root;
	endfunction

	// One axis of the drive: magnitude scaled, truncated toward zero
	function automatic logic signed [COORD_W-1:0] scaled_drive(input longint d,
			input longint root);
		longint mag;
		longint q;
		mag = (d < 0) ? -d : d;
		q = (longint'(cfg_drive) * mag) / root;
		if (d < 0)
			q = -q;
		return q[COORD_W-1:0];
	endfunction

	// Advance the model by one accepted beat; queue the drive at frame end
	function automatic void predict_beat(input logic signed [COORD_W-1:0] dx,
			input logic signed [COORD_W-1:0] dy, input logic p, input logic last);
		longint sq;
		longint lim;
		longint hx;
		longint hy;
		longint root;
		drive_result_t r;
		if (beat_count < LKDV_MAX_NEIGHBOURS) begin
			if (p && !held_found) begin
				sq = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
				lim = longint'(cfg_reach) * longint'(cfg_reach);
				if (sq > lim) begin
					held_found = 1'b1;
					held_x = dx;
					held_y = dy;
					held_idx = beat_count[CNT_W-1:0];
				end
			end
			beat_count++;
		end
		if (last) begin
			r = '{x: '0, y: '0, sig: 1'b0, idx: '0};
			if (held_found) begin
				hx = longint'(held_x);
				hy = longint'(held_y);
				root = floor_sqrt(hx * hx + hy * hy);
				if (root == 0)
					root = 1;
				r.x = scaled_drive(hx, root);
				r.y = scaled_drive(hy, root);
				r.sig = 1'b1;
				r.idx = held_idx;
			end
			expected_drives.push_back(r);
			held_found = 1'b0;
			held_x = '0;
			held_y = '0;
			held_idx = '0;
			beat_count = 0;
		end
	endfunction

	// Offer one beat, hold it until taken, then update the model
	task automatic send_offset(input logic signed [COORD_W-1:0] dx,
			input logic signed [COORD_W-1:0] dy, input logic p, input logic last);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		offset_x <= dx;
		offset_y <= dy;
		present <= p;
		frame_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_beat(dx, dy, p, last);
	endtask

	// Drop valid and wait until every drive beat is out and the block is quiet
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_drives.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write a register, then read it back
	task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] want;
		drain_results();
		want = (idx == REG_REACH) ? (value & 32'hFFFF) : (value & 32'h7FFF);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_REACH)
			cfg_reach = want[15:0];
		else
			cfg_drive = want[14:0];
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			flag_mismatch("register readback", prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_registers(input logic [31:0] reach, input logic [31:0] drive);
		write_register(REG_REACH, reach);
		write_register(REG_DRIVE, drive);
	endtask

	// Offsets biased around the threshold so both sides of the compare show up
	function automatic logic signed [COORD_W-1:0] pick_offset();
		int span;
		int v;
		case ($urandom_range(3))
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: begin
				span = int'(cfg_reach) + int'(cfg_reach) / 4 + 2;
				v = int'($urandom_range(0, 2 * span)) - span;
			end
			2: v = $urandom_range(1) ? int'(cfg_reach) : -int'(cfg_reach);
			default: begin
				case ($urandom_range(3))
					0: v = -32768;
					1: v = 32767;
					default: v = int'($urandom_range(0, 6)) - 3;
				endcase
			end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [31:0] pick_reach();
		case ($urandom_range(4))
			0: return 32'd0;
			1: return 32'd65535;
			2: return $urandom_range(1, 300);
			3: return $urandom_range(0, 65535);
			default: return 32'd46340;
		endcase
	endfunction

	function automatic logic [31:0] pick_drive();
		case ($urandom_range(3))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd32767;
			default: return $urandom_range(0, 32767);
		endcase
	endfunction

	// Zero offsets and absent neighbours never qualify, even at reset settings
	task automatic test_no_signal();
		send_offset(16'sd0, 16'sd0, 1'b1, 1'b1);
		send_offset(16'sd100, -16'sd5, 1'b0, 1'b1);
	endtask

	// Zero threshold: first present nonzero offset wins, full drive
	task automatic test_zero_threshold();
		set_registers(32'd0, 32'd32767);
		send_offset(16'sd0, 16'sd0, 1'b1, 1'b0);
		send_offset(-16'sd7, 16'sd9, 1'b0, 1'b0);
		send_offset(-16'sd32768, 16'sd0, 1'b1, 1'b0);
		send_offset(16'sd32767, 16'sd32767, 1'b1, 1'b1);
	endtask

	// Squared distance equal to the threshold squared does not qualify
	task automatic test_threshold_edge();
		set_registers(32'd5, 32'd1000);
		send_offset(16'sd3, 16'sd4, 1'b1, 1'b0);
		send_offset(-16'sd4, -16'sd3, 1'b1, 1'b0);
		send_offset(16'sd4, -16'sd4, 1'b1, 1'b1);
		set_registers(32'd46340, 32'd1);
		send_offset(-16'sd32768, -16'sd32768, 1'b1, 1'b1);
		set_registers(32'd65535, 32'd32767);
		send_offset(16'sd32767, -16'sd32768, 1'b1, 1'b1);
	endtask

	// Beats past the neighbour limit are ignored, but frame end still counts
	task automatic test_saturation();
		set_registers(32'd0, 32'd1);
		for (int k = 0; k < 10; k++)
			send_offset(pick_offset(), pick_offset(), k >= 8, k == 9);
	endtask

	// Random frames, mostly within the neighbour limit, some overlong
	task automatic test_random_frames(input int n_beats);
		int sent;
		int len;
		logic p;
		sent = 0;
		while (sent < n_beats) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				p = ($urandom_range(9) != 0);
				send_offset(pick_offset(), pick_offset(), p, k == len - 1);
			end
			sent += len;
			if ($urandom_range(11) == 0)
				drain_results();
		end
	endtask

	// Compare each drive beat with the oldest expectation; stall at random
	always @(posedge clk) begin : check_drives
		drive_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (out_valid && !out_stall) begin
				if (expected_drives.size() == 0) begin
					flag_mismatch("drive beat with none pending", has_signal, 0);
				end else begin
					want = expected_drives.pop_front();
					if (drive_x !== want.x)
						flag_mismatch("drive_x", drive_x, want.x);
					if (drive_y !== want.y)
						flag_mismatch("drive_y", drive_y, want.y);
					if (has_signal !== want.sig)
						flag_mismatch("has_signal", has_signal, want.sig);
					if (chosen_index !== want.idx)
						flag_mismatch("chosen_index", chosen_index, want.idx);
				end
			end
		end
	end

	initial begin
		error_count = 0;
		gap_pct = 23;
		stall_pct = 61;
		cfg_reach = '0;
		cfg_drive = '0;
		held_found = 1'b0;
		held_x = '0;
		held_y = '0;
		held_idx = '0;
		beat_count = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		offset_x <= '0;
		offset_y <= '0;
		present <= 1'b0;
		frame_end <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_signal();
		test_zero_threshold();
		test_threshold_edge();
		test_saturation();

		// Three idle mixes, two register settings each
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 23 : (ph == 1) ? 61 : 0;
			stall_pct = (ph == 0) ? 61 : (ph == 1) ? 23 : 0;
			for (int c = 0; c < 2; c++) begin
				set_registers(pick_reach(), pick_drive());
				test_random_frames(100);
			end
		end

		drain_results();
		if (error_count == 0)
			$display("link_keeping_drive_vector verification clean");
		else
			$display("link_keeping_drive_vector verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/lkdv_pkg.sv
design/lkdv_arith.sv
design/lkdv_qualify.sv
design/lkdv_scale.sv
design/link_keeping_drive_vector.sv
design/lkdv_checker.sv
dv/link_keeping_drive_vector_tb.sv
